FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants shared by the keyed table with swap-remove.
// ----------------------------------------------------------------------------
package kts_pkg;

	// Default table depth
	localparam int SLOTS_DEF = 64;

	// Fixed field widths
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int QUOTA_W  = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_F_W = 6;
	localparam int COUNT_W  = 7;
	localparam int SUM_W    = 22;

	// Stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_F_W + QUOTA_W + COUNT_W + SUM_W);

	// Entry word in the table memory: {quota, key}
	localparam int ENTRY_W = KEY_W + QUOTA_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2
	} kts_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} kts_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_RDLAST,
		S_MOVE,
		S_DONE
	} kts_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [KEY_W-1:0]   key;
		logic [QUOTA_W-1:0] quota;
	} kts_req_t;

	typedef struct packed {
		kts_status_t         status;
		logic [SLOT_F_W-1:0] slot;
		logic [QUOTA_W-1:0]  found_quota;
		logic [COUNT_W-1:0]  entry_count;
		logic [SUM_W-1:0]    total_quota;
	} kts_result_t;

endpackage

FILE: design/keyed_table_swap_remove_core.sv
// ----------------------------------------------------------------------------
// keyed_table_swap_remove_core
// Keyed table of SLOTS entries with add, find and swap-remove requests.
// ----------------------------------------------------------------------------
// Usage:
//   One request word enters on the s_axis channel (command in tuser, key and
//   quota in tdata) and exactly one result word leaves on m_axis (status in
//   tuser; slot, found quota, entry count and quota total in tdata).
//   Requests are handled one at a time; s_axis_tready rises as the result word
//   goes valid, so a new request is taken only once the last result is valid.
// Steps, from the accepting edge to the result word being valid:
//   add: S_ADD, S_DONE; unknown command: S_DONE.
//   find: the walk, S_DONE; remove: the walk, S_RDLAST, S_MOVE, S_DONE.
//   S_DONE loads the output register. The walk runs through the table
//   memory at one stored key per cycle on a single comparator.
// Reset clears the entry count, the quota total and all control state; the
// memory itself is not cleared, since only written slots are ever read.
// A stalled receiver holds the result in the output register; the next
// request is still taken and worked, and its result waits in the sequencer
// until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_table_swap_remove_core #(
	parameter int SLOTS = kts_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// key [31:0], quota [47:32]
	input  logic [kts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// command [1:0]
	input  logic [kts_pkg::CMD_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// slot [5:0], found_quota [21:6], entry_count [28:22],
	// total_quota [50:29], zero [55:51]
	output logic [kts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// status [1:0]
	output logic [kts_pkg::STATUS_W-1:0]        m_axis_tuser
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	kts_pkg::kts_req_t    req;
	kts_pkg::kts_result_t res;
	kts_pkg::kts_result_t out_q;
	logic                 out_vld_q;
	logic                 res_valid;
	logic                 res_ready;

	logic                          mem_we;
	logic [SLOT_W-1:0]             mem_waddr;
	logic [kts_pkg::ENTRY_W-1:0]   mem_wdata;
	logic [SLOT_W-1:0]             mem_raddr;
	logic [kts_pkg::ENTRY_W-1:0]   mem_rdata;

	// Unpack the request word
	assign req.command = s_axis_tuser;
	assign req.key     = s_axis_tdata[kts_pkg::KEY_W-1:0];
	assign req.quota   = s_axis_tdata[kts_pkg::ENTRY_W-1:kts_pkg::KEY_W];

	kts_seq #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W),
		.CNT_W  (CNT_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	kts_mem #(
		.DEPTH (SLOTS),
		.AW    (SLOT_W),
		.DW    (kts_pkg::ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Pack the result word
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {{kts_pkg::OUT_PAD_W{1'b0}}, out_q.total_quota,
		out_q.entry_count, out_q.found_quota, out_q.slot};

	// A taken request blocks the input for at least the next cycle
	`ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input ready right after a request was taken")

	// A full table answers with slot zero and no quota
	`ASSERT_SAME(a_full_slot_zero,
		m_axis_tvalid && m_axis_tuser == kts_pkg::ST_FULL,
		m_axis_tdata[21:0] == 22'd0,
		"full status with nonzero slot or quota")

	// A missed search answers with slot zero and no quota
	`ASSERT_SAME(a_miss_slot_zero,
		m_axis_tvalid && m_axis_tuser == kts_pkg::ST_MISSING,
		m_axis_tdata[21:0] == 22'd0,
		"missing status with nonzero slot or quota")

	// The reported entry count never exceeds the table depth
	`ASSERT_SAME(a_count_in_range, m_axis_tvalid,
		32'(m_axis_tdata[28:22]) <= 32'(SLOTS),
		"entry count beyond table depth")

endmodule

FILE: design/kts_mem.sv
// ----------------------------------------------------------------------------
// kts_mem
// Table entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kts_mem #(
	parameter int DEPTH = kts_pkg::SLOTS_DEF,
	parameter int AW    = 6,
	parameter int DW    = kts_pkg::ENTRY_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data valid in the cycle after the address
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/kts_seq.sv
// ----------------------------------------------------------------------------
// kts_seq
// Request sequencer: appends entries, walks the table one slot per cycle
// through the shared key comparator, and performs the swap-remove.
// ----------------------------------------------------------------------------
module kts_seq #(
	parameter int SLOTS  = kts_pkg::SLOTS_DEF,
	parameter int SLOT_W = 6,
	parameter int CNT_W  = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          req_valid,
	output logic                          req_ready,
	input  kts_pkg::kts_req_t             req,
	// result side
	output logic                          res_valid,
	input  logic                          res_ready,
	output kts_pkg::kts_result_t          res,
	// table memory
	output logic                          mem_we,
	output logic [SLOT_W-1:0]             mem_waddr,
	output logic [kts_pkg::ENTRY_W-1:0]   mem_wdata,
	output logic [SLOT_W-1:0]             mem_raddr,
	input  logic [kts_pkg::ENTRY_W-1:0]   mem_rdata
);

	kts_pkg::kts_state_t  state_q, state_d;
	kts_pkg::kts_req_t    req_q;
	kts_pkg::kts_result_t res_q;
	logic [CNT_W-1:0]             count_q;
	logic [kts_pkg::SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]             idx_q;
	logic                         vld_s1;
	logic [SLOT_W-1:0]            idx_s1;
	logic [SLOT_W-1:0]            hit_q;

	logic                         accept;
	logic                         is_full;
	logic                         scan_issue;
	logic                         match;
	logic                         scan_miss;
	logic [kts_pkg::KEY_W-1:0]    rd_key;
	logic [kts_pkg::QUOTA_W-1:0]  rd_quota;
	logic [CNT_W-1:0]             last_idx;

	assign accept    = req_valid && req_ready;
	assign is_full   = count_q >= CNT_W'(SLOTS);
	assign rd_key    = mem_rdata[kts_pkg::KEY_W-1:0];
	assign rd_quota  = mem_rdata[kts_pkg::ENTRY_W-1:kts_pkg::KEY_W];
	assign last_idx  = count_q - CNT_W'(1);

	// Shared comparator: one stored key against the request key per cycle
	assign scan_issue = (state_q == kts_pkg::S_SCAN) && (idx_q < count_q);
	assign match      = (state_q == kts_pkg::S_SCAN) && vld_s1 && (rd_key == req_q.key);
	assign scan_miss  = (state_q == kts_pkg::S_SCAN) && !vld_s1 && !(idx_q < count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kts_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req.command)
						kts_pkg::CMD_ADD:    state_d = kts_pkg::S_ADD;
						kts_pkg::CMD_FIND:   state_d = kts_pkg::S_SCAN;
						kts_pkg::CMD_REMOVE: state_d = kts_pkg::S_SCAN;
						default:             state_d = kts_pkg::S_DONE;
					endcase
				end
			end
			kts_pkg::S_ADD:    state_d = kts_pkg::S_DONE;
			kts_pkg::S_SCAN: begin
				if (match) begin
					state_d = (req_q.command == kts_pkg::CMD_REMOVE) ?
						kts_pkg::S_RDLAST : kts_pkg::S_DONE;
				end else if (scan_miss) begin
					state_d = kts_pkg::S_DONE;
				end
			end
			kts_pkg::S_RDLAST: state_d = kts_pkg::S_MOVE;
			kts_pkg::S_MOVE:   state_d = kts_pkg::S_DONE;
			kts_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = kts_pkg::S_IDLE;
				end
			end
			default:           state_d = kts_pkg::S_IDLE;
		endcase
	end

	// Outputs and memory control
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[SLOT_W-1:0];
		mem_wdata = {req_q.quota, req_q.key};
		mem_raddr = idx_q[SLOT_W-1:0];
		case (state_q)
			kts_pkg::S_IDLE:   req_ready = 1'b1;
			kts_pkg::S_ADD:    mem_we = !is_full;
			kts_pkg::S_SCAN:   mem_raddr = idx_q[SLOT_W-1:0];
			kts_pkg::S_RDLAST: mem_raddr = last_idx[SLOT_W-1:0];
			kts_pkg::S_MOVE: begin
				// move the last entry into the freed slot
				mem_we    = 1'b1;
				mem_waddr = hit_q;
				mem_wdata = mem_rdata;
			end
			kts_pkg::S_DONE:   res_valid = 1'b1;
			default: ;
		endcase
	end

	// State register and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kts_pkg::S_IDLE;
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (state_q == kts_pkg::S_ADD && !is_full) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + kts_pkg::SUM_W'(req_q.quota);
			end
			if (match && req_q.command == kts_pkg::CMD_REMOVE) begin
				sum_q <= sum_q - kts_pkg::SUM_W'(rd_quota);
			end
			if (state_q == kts_pkg::S_MOVE) begin
				count_q <= last_idx;
			end
		end
	end

	// Request hold, scan pipeline index and result word
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[SLOT_W-1:0];
		if (accept) begin
			req_q <= req;
			// preset the miss answer; success paths overwrite it
			res_q.status      <= kts_pkg::ST_MISSING;
			res_q.slot        <= '0;
			res_q.found_quota <= '0;
			res_q.entry_count <= kts_pkg::COUNT_W'(count_q);
			res_q.total_quota <= sum_q;
		end
		if (state_q == kts_pkg::S_ADD) begin
			if (is_full) begin
				res_q.status <= kts_pkg::ST_FULL;
			end else begin
				res_q.status      <= kts_pkg::ST_OK;
				res_q.slot        <= kts_pkg::SLOT_F_W'(count_q);
				res_q.entry_count <= kts_pkg::COUNT_W'(count_q + CNT_W'(1));
				res_q.total_quota <= sum_q + kts_pkg::SUM_W'(req_q.quota);
			end
		end
		if (match) begin
			hit_q        <= idx_s1;
			res_q.status <= kts_pkg::ST_OK;
			res_q.slot   <= kts_pkg::SLOT_F_W'(idx_s1);
			if (req_q.command == kts_pkg::CMD_REMOVE) begin
				res_q.total_quota <= sum_q - kts_pkg::SUM_W'(rd_quota);
			end else begin
				res_q.found_quota <= rd_quota;
			end
		end
		if (state_q == kts_pkg::S_MOVE) begin
			res_q.entry_count <= kts_pkg::COUNT_W'(last_idx);
		end
	end

	assign res = res_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_table_swap_remove_core: drives add, find,
// remove and unused request words with random idling and back-pressure,
// predicts each result word from a local copy of the table, and compares
// every result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

	localparam int TABLE_DEPTH = kts_pkg::SLOTS_DEF;
	localparam logic [kts_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_N       = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 100;
	localparam int LONG_HOLD    = 300;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// key [31:0], quota [47:32]
	logic [kts_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	// command [1:0]
	logic [kts_pkg::CMD_W-1:0]       s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// slot [5:0], found_quota [21:6], entry_count [28:22],
	// total_quota [50:29], zero [55:51]
	logic [kts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// status [1:0]
	logic [kts_pkg::STATUS_W-1:0]    m_axis_tuser;

	// Predicted table contents and the result words still owed
	logic [kts_pkg::KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
	logic [kts_pkg::QUOTA_W-1:0] tbl_quota [TABLE_DEPTH];
	int                          tbl_count;
	logic [kts_pkg::SUM_W-1:0]   tbl_sum;
	kts_pkg::kts_result_t        pending_results [$];

	logic [kts_pkg::KEY_W-1:0]   key_pool [POOL_N];
	int                          mismatches;
	bit                          idle_on;
	int                          rx_hold_cycles;
	kts_pkg::kts_result_t        got_word;
	kts_pkg::kts_result_t        want_word;

	keyed_table_swap_remove_core #(
		.SLOTS(TABLE_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one request to the local table and return the result word it owes
	function automatic kts_pkg::kts_result_t table_apply(logic [kts_pkg::CMD_W-1:0] cmd,
			logic [kts_pkg::KEY_W-1:0] key, logic [kts_pkg::QUOTA_W-1:0] quota);
		kts_pkg::kts_result_t r;
		int                   hit;
		r        = '0;
		r.status = kts_pkg::ST_MISSING;
		hit      = -1;
		for (int i = 0; i < tbl_count; i++)
			if (hit < 0 && tbl_key[i] == key)
				hit = i;
		case (cmd)
			kts_pkg::CMD_ADD: begin
				if (tbl_count >= TABLE_DEPTH) begin
					r.status = kts_pkg::ST_FULL;
				end else begin
					tbl_key[tbl_count]   = key;
					tbl_quota[tbl_count] = quota;
					r.slot    = tbl_count[kts_pkg::SLOT_F_W-1:0];
					tbl_count = tbl_count + 1;
					tbl_sum   = tbl_sum + quota;
					r.status  = kts_pkg::ST_OK;
				end
			end
			kts_pkg::CMD_FIND: begin
				if (hit >= 0) begin
					r.status      = kts_pkg::ST_OK;
					r.slot        = hit[kts_pkg::SLOT_F_W-1:0];
					r.found_quota = tbl_quota[hit];
				end
			end
			kts_pkg::CMD_REMOVE: begin
				// swap the last entry into the freed slot
				if (hit >= 0) begin
					tbl_sum        = tbl_sum - tbl_quota[hit];
					tbl_key[hit]   = tbl_key[tbl_count-1];
					tbl_quota[hit] = tbl_quota[tbl_count-1];
					tbl_count      = tbl_count - 1;
					r.status       = kts_pkg::ST_OK;
					r.slot         = hit[kts_pkg::SLOT_F_W-1:0];
				end
			end
			default: ;
		endcase
		r.entry_count = tbl_count[kts_pkg::COUNT_W-1:0];
		r.total_quota = tbl_sum;
		return r;
	endfunction

	task automatic note_mismatch(string what, longint got, longint want);
		if (mismatches < MAX_REPORTS)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	// Check each accepted result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_word.status      = kts_pkg::kts_status_t'(m_axis_tuser);
			got_word.slot        = m_axis_tdata[5:0];
			got_word.found_quota = m_axis_tdata[21:6];
			got_word.entry_count = m_axis_tdata[28:22];
			got_word.total_quota = m_axis_tdata[50:29];
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result word (pending count)", 1, 0);
			end else begin
				want_word = pending_results.pop_front();
				if (got_word.status !== want_word.status)
					note_mismatch("status", got_word.status, want_word.status);
				if (got_word.slot !== want_word.slot)
					note_mismatch("slot", got_word.slot, want_word.slot);
				if (got_word.found_quota !== want_word.found_quota)
					note_mismatch("found_quota", got_word.found_quota, want_word.found_quota);
				if (got_word.entry_count !== want_word.entry_count)
					note_mismatch("entry_count", got_word.entry_count, want_word.entry_count);
				if (got_word.total_quota !== want_word.total_quota)
					note_mismatch("total_quota", got_word.total_quota, want_word.total_quota);
			end
		end
	end

	// Drive the result-side ready: random stall bursts, or a long requested hold
	initial begin : rx_ready_proc
		int n;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				n              = rx_hold_cycles;
				rx_hold_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one request word, hold it until accepted, then predict its result
	task automatic send_word(logic [kts_pkg::CMD_W-1:0] cmd, logic [kts_pkg::KEY_W-1:0] key,
			logic [kts_pkg::QUOTA_W-1:0] quota);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {quota, key};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(table_apply(cmd, key, quota));
	endtask

	// Drop valid and hold until every owed result word has arrived
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Mostly keys that may hit, sometimes a fresh random key
	function automatic logic [kts_pkg::KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		if (r < 8 && tbl_count > 0)
			return tbl_key[$urandom_range(0, tbl_count - 1)];
		return $urandom;
	endfunction

	task automatic test_empty_table();
		send_word(kts_pkg::CMD_FIND, 32'h0, 16'h0);
		send_word(kts_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(CMD_UNUSED, 32'h0, 16'h0);
	endtask

	task automatic test_basic_ops();
		send_word(kts_pkg::CMD_ADD, 32'h0, 16'h0);
		send_word(kts_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(kts_pkg::CMD_ADD, 32'h0, 16'h0001);
		send_word(kts_pkg::CMD_ADD, 32'hA5A5_5A5A, 16'h8000);
		// first match wins on duplicate keys
		send_word(kts_pkg::CMD_FIND, 32'h0, 16'hFFFF);
		send_word(kts_pkg::CMD_FIND, 32'hFFFF_FFFF, 16'h0);
		send_word(kts_pkg::CMD_FIND, 32'h1234_5678, 16'h0);
		send_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		// swap-remove moves the last entry into slot zero
		send_word(kts_pkg::CMD_REMOVE, 32'h0, 16'h0);
		send_word(kts_pkg::CMD_FIND, 32'hA5A5_5A5A, 16'h0);
		send_word(kts_pkg::CMD_FIND, 32'h0, 16'h0);
		send_word(kts_pkg::CMD_REMOVE, 32'h5A5A_A5A5, 16'h0);
		// remove of the last entry just drops it
		send_word(kts_pkg::CMD_REMOVE, 32'h0, 16'h0);
		send_word(kts_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0);
		send_word(kts_pkg::CMD_REMOVE, 32'hA5A5_5A5A, 16'h0);
		send_word(kts_pkg::CMD_FIND, 32'hA5A5_5A5A, 16'h0);
	endtask

	task automatic test_random_mix(int count, int add_pct);
		int                        r;
		int                        find_lim;
		logic [kts_pkg::CMD_W-1:0] cmd;
		find_lim = add_pct + (95 - add_pct) / 2;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < add_pct)
				cmd = kts_pkg::CMD_ADD;
			else if (r < find_lim)
				cmd = kts_pkg::CMD_FIND;
			else if (r < 95)
				cmd = kts_pkg::CMD_REMOVE;
			else
				cmd = CMD_UNUSED;
			send_word(cmd, pick_key(), 16'($urandom));
		end
	endtask

	// Hold the result side for a long stretch while requests keep coming
	task automatic test_backpressure();
		rx_hold_cycles = LONG_HOLD;
		test_random_mix(10, 50);
	endtask

	task automatic test_drain_pause();
		wait_drained();
		test_random_mix(6, 40);
	endtask

	// Fill at the largest quota, overflow, then hit the top slot
	task automatic test_table_full();
		while (tbl_count < TABLE_DEPTH)
			send_word(kts_pkg::CMD_ADD, pick_key(), 16'hFFFF);
		send_word(kts_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(kts_pkg::CMD_ADD, $urandom, 16'($urandom));
		send_word(kts_pkg::CMD_FIND, tbl_key[TABLE_DEPTH-1], 16'h0);
		send_word(kts_pkg::CMD_REMOVE, tbl_key[TABLE_DEPTH-1], 16'h0);
		send_word(kts_pkg::CMD_ADD, $urandom, 16'h0);
		send_word(kts_pkg::CMD_REMOVE, tbl_key[0], 16'h0);
	endtask

	// Remove stored keys until the table is empty
	task automatic test_empty_out();
		while (tbl_count > 0)
			send_word(kts_pkg::CMD_REMOVE, tbl_key[$urandom_range(0, tbl_count - 1)],
				16'($urandom));
		send_word(kts_pkg::CMD_REMOVE, key_pool[0], 16'h0);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		tbl_count      = 0;
		tbl_sum        = '0;
		mismatches     = 0;
		rx_hold_cycles = 0;
		idle_on        = 1'b1;
		key_pool[0]    = 32'h0;
		key_pool[1]    = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_basic_ops();
		test_random_mix(350, 40);
		test_backpressure();
		test_drain_pause();
		test_table_full();
		test_empty_out();
		test_random_mix(250, 60);
		idle_on = 1'b0;
		test_random_mix(400, 45);

		// Let the last result words arrive, then report
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: keyed_table_swap_remove_core.f
+incdir+design
design/kts_pkg.sv
design/kts_mem.sv
design/kts_seq.sv
design/keyed_table_swap_remove_core.sv
verif/tb.sv
